@@ hw/rtl/plse_pkg.sv @@
// ----------------------------------------------------------------------------
// plse_pkg
// shared widths, codes, sequencer states and divider status for the
// piecewise linear spectrum evaluator
// ----------------------------------------------------------------------------
package plse_pkg;

   // field widths
   localparam int WL_W      = 16;              // wavelength, unsigned Q10.6
   localparam int VAL_W     = 24;              // value, signed Q8.16
   localparam int CNT_W     = 7;               // point_count register
   localparam int IDX_W     = 6;               // entry_index field
   localparam int ENTRY_W   = WL_W + VAL_W;    // one table word

   // interpolation fraction, Q0.16 with 1.0 reachable
   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = 4;               // quotient bits per divider cycle
   localparam int PROD_W    = (VAL_W + 1) + (FRAC_BITS + 2);
   localparam int ROUND_HALF = 32768;

   localparam logic [FRAC_BITS:0]          FRAC_ONE  = 17'h10000;
   localparam logic signed [VAL_W-1:0]     VAL_ZERO  = 24'sh000000;
   localparam logic signed [VAL_W-1:0]     VAL_MAX   = 24'sh7fffff;
   localparam logic signed [VAL_W-1:0]     VAL_MIN   = 24'sh800000;

   // item codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CHECK,
      ST_SRCH_ISSUE,
      ST_SRCH_CMP,
      ST_RD_PREV,
      ST_RD_CUR,
      ST_PAIR,
      ST_DIV,
      ST_MUL,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hw/rtl/piecewise_linear_spectrum_eval_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_spectrum_eval_unit
// breakpoint table with binary search and linear interpolation
// ----------------------------------------------------------------------------
// The block holds up to MAX_POINTS breakpoints (wavelength Q10.6, value
// Q8.16 signed) in one synchronous table memory. A load transfer
// (req_mode 0) writes one slot and leaves the block idle; a slot at or
// above MAX_POINTS is dropped. An evaluate transfer (req_mode 1) returns
// one result: zero with rsp_outside_range set when point_count is zero or
// the query lies outside the first and last breakpoints, otherwise the
// value interpolated between the breakpoint found by binary search and the
// one before it, rounded and saturated; the value of the first slot when
// the search finds that slot, and the right point's value for a
// non-increasing pair. point_count above MAX_POINTS is taken as
// MAX_POINTS. The table holds garbage until a slot is loaded and must be
// loaded before it is evaluated. Evaluation is sequenced over the one
// table read port: it reads the first and last breakpoints, runs the
// binary search with one read per step, reads the pair, then runs the
// fraction divider, the multiply and the round. The finished result waits
// until the output register is free; it then sits in that register, so
// the next item is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module piecewise_linear_spectrum_eval_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,

   // configuration
   input  logic                                csr_we,
   input  logic [plse_pkg::CNT_W-1:0]          csr_wdata,

   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [plse_pkg::IDX_W-1:0]          req_entry_index,
   input  logic [plse_pkg::WL_W-1:0]           req_point_wavelength,
   input  logic signed [plse_pkg::VAL_W-1:0]   req_point_value,
   input  logic [plse_pkg::WL_W-1:0]           req_query_wavelength,

   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [plse_pkg::VAL_W-1:0]   rsp_spectral_value,
   output logic                                rsp_outside_range
);
   import plse_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);        // table address
   localparam int NW = $clog2(MAX_POINTS + 1);    // counts up to MAX_POINTS
   localparam int CW = (NW > CNT_W) ? NW : CNT_W; // count clamp compare
   localparam int SW = (NW > IDX_W) ? NW : IDX_W; // slot range compare
   localparam int SHW   = PROD_W - FRAC_BITS;     // product after >> 16
   localparam int SUM_W = SHW + 1;

   // table memory
   logic [ENTRY_W-1:0] mem [MAX_POINTS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               mem_we;
   logic [WL_W-1:0]    rd_wl;
   logic signed [VAL_W-1:0] rd_val;

   // sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        point_count_ff;
   logic [WL_W-1:0]         query_ff, query_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [NW-1:0]           lo_ff, lo_in;
   logic [NW-1:0]           hi_ff, hi_in;
   logic [NW-1:0]           mid_ff, mid_in;
   logic [NW-1:0]           idx_ff, idx_in;
   logic [WL_W-1:0]         w_first_ff, w_first_in;
   logic signed [VAL_W-1:0] v_first_ff, v_first_in;
   logic [WL_W-1:0]         w0_ff, w0_in;
   logic signed [VAL_W-1:0] v0_ff, v0_in;
   logic signed [VAL_W-1:0] v1_ff, v1_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VAL_W-1:0] res_value_ff, res_value_in;
   logic                    res_outside_ff, res_outside_in;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_outside_ff;
   logic                    rsp_load;

   // combinational helpers
   logic [SW-1:0]           slot_ext;
   logic                    slot_ok;
   logic [CW-1:0]           pc_ext;
   logic [CW-1:0]           n_full;
   logic [NW-1:0]           n_eff;
   logic [NW-1:0]           n_minus1;
   logic [NW-1:0]           idx_minus1;
   logic [NW-1:0]           mid_calc;
   logic [NW-1:0]           pick;
   logic [WL_W-1:0]         den_w;
   logic [WL_W-1:0]         num_raw;
   logic [WL_W-1:0]         num_w;
   logic                    div_start;
   logic [FRAC_BITS:0]      quot;
   div_status_type          div_stat;
   logic signed [VAL_W:0]   diff_v;
   logic signed [FRAC_BITS+1:0] t_s;
   logic [PROD_W-1:0]       rnd;
   logic [SHW-1:0]          shifted;
   logic signed [SUM_W-1:0] sum_v;
   logic signed [VAL_W-1:0] sat_v;

   assign rd_wl  = rd_data_ff[ENTRY_W-1:VAL_W];
   assign rd_val = rd_data_ff[VAL_W-1:0];

   // load slot range check, table address
   assign slot_ext = SW'(req_entry_index);
   assign slot_ok  = slot_ext < SW'(MAX_POINTS);
   assign wr_addr  = slot_ext[AW-1:0];

   // point count clamped to the table depth
   assign pc_ext = CW'(point_count_ff);
   assign n_full = (pc_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext;
   assign n_eff  = n_full[NW-1:0];

   // search indexes
   assign n_minus1   = n_ff - NW'(1);
   assign idx_minus1 = idx_ff - NW'(1);
   assign mid_calc   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pick       = (lo_ff >= n_ff) ? n_minus1 : lo_ff;  // search ran off the end

   // divider operands, rd_data holds the right breakpoint in ST_PAIR
   assign den_w   = rd_wl - w0_ff;
   assign num_raw = (query_ff > w0_ff) ? (query_ff - w0_ff) : '0;
   assign num_w   = (num_raw > den_w) ? den_w : num_raw;

   // interpolation arithmetic
   assign diff_v  = {v1_ff[VAL_W-1], v1_ff} - {v0_ff[VAL_W-1], v0_ff};
   assign t_s     = $signed({1'b0, quot});
   assign rnd     = prod_ff + PROD_W'(ROUND_HALF);
   assign shifted = rnd[PROD_W-1:FRAC_BITS];                // floor of /2^16
   assign sum_v   = $signed({{(SUM_W-VAL_W){v0_ff[VAL_W-1]}}, v0_ff})
                  + $signed({shifted[SHW-1], shifted});

   // saturate to 24 bits
   always_comb begin
      if ((&sum_v[SUM_W-1:VAL_W-1]) || !(|sum_v[SUM_W-1:VAL_W-1])) begin
         sat_v = sum_v[VAL_W-1:0];
      end else if (sum_v[SUM_W-1]) begin
         sat_v = VAL_MIN;
      end else begin
         sat_v = VAL_MAX;
      end
   end

   plse_frac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_w),
      .den    (den_w),
      .quot   (quot),
      .status (div_stat)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      query_in       = query_ff;
      n_in           = n_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      idx_in         = idx_ff;
      w_first_in     = w_first_ff;
      v_first_in     = v_first_ff;
      w0_in          = w0_ff;
      v0_in          = v0_ff;
      v1_in          = v1_ff;
      prod_in        = prod_ff;
      res_value_in   = res_value_ff;
      res_outside_in = res_outside_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  mem_we = slot_ok;
               end else begin
                  query_in = req_query_wavelength;
                  n_in     = n_eff;
                  if (n_eff == '0) begin
                     // empty table
                     res_value_in   = VAL_ZERO;
                     res_outside_in = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_RD_FIRST;
                  end
               end
            end
         end
         ST_RD_FIRST: begin
            rd_addr  = '0;
            state_in = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            rd_addr    = n_minus1[AW-1:0];
            w_first_in = rd_wl;
            v_first_in = rd_val;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            // rd_data holds the last point in use
            if ((query_ff < w_first_ff) || (query_ff > rd_wl)) begin
               res_value_in   = VAL_ZERO;
               res_outside_in = 1'b1;
               state_in       = ST_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = ST_SRCH_ISSUE;
            end
         end
         ST_SRCH_ISSUE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[AW-1:0];
               state_in = ST_SRCH_CMP;
            end else begin
               idx_in = pick;
               if (pick == '0) begin
                  // first slot found, its value as is
                  res_value_in   = v_first_ff;
                  res_outside_in = 1'b0;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_RD_PREV;
               end
            end
         end
         ST_SRCH_CMP: begin
            if (rd_wl < query_ff) begin
               lo_in = mid_ff + NW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH_ISSUE;
         end
         ST_RD_PREV: begin
            rd_addr  = idx_minus1[AW-1:0];
            state_in = ST_RD_CUR;
         end
         ST_RD_CUR: begin
            rd_addr  = idx_ff[AW-1:0];
            w0_in    = rd_wl;
            v0_in    = rd_val;
            state_in = ST_PAIR;
         end
         ST_PAIR: begin
            v1_in = rd_val;
            if (rd_wl <= w0_ff) begin
               // non-increasing pair, right point's value
               res_value_in   = rd_val;
               res_outside_in = 1'b0;
               state_in       = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = diff_v * t_s;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            res_value_in   = sat_v;
            res_outside_in = 1'b0;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {req_point_wavelength, req_point_value};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            point_count_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      query_ff       <= query_in;
      n_ff           <= n_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      idx_ff         <= idx_in;
      w_first_ff     <= w_first_in;
      v_first_ff     <= v_first_in;
      w0_ff          <= w0_in;
      v0_ff          <= v0_in;
      v1_ff          <= v1_in;
      prod_ff        <= prod_in;
      res_value_ff   <= res_value_in;
      res_outside_ff <= res_outside_in;
      if (rsp_load) begin
         rsp_value_ff   <= res_value_ff;
         rsp_outside_ff <= res_outside_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_spectral_value = rsp_value_ff;
   assign rsp_outside_range  = rsp_outside_ff;

   // search window stays inside the points in use
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_ISSUE) |-> (lo_ff <= hi_ff) && (hi_ff <= n_ff))
      else $error("search window out of bounds");

   // probe lies inside the window
   a_probe_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_CMP) |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("search probe outside window");

   // divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside ST_DIV");

   // divider stays busy for the whole wait
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> div_stat.busy)
      else $error("divider idle during ST_DIV");

   // fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |=> (quot <= FRAC_ONE))
      else $error("interpolation fraction above one");

   // a new result only comes from the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside ST_DONE");

endmodule

@@ hw/rtl/plse_frac_div.sv @@
// ----------------------------------------------------------------------------
// plse_frac_div
// rounded fraction t = (num * 2^16 + den / 2) / den for num <= den,
// radix-16 restoring divider, four quotient bits per cycle
// ----------------------------------------------------------------------------
module plse_frac_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plse_pkg::WL_W-1:0]      num,
   input  logic [plse_pkg::WL_W-1:0]      den,
   output logic [plse_pkg::FRAC_BITS:0]   quot,
   output plse_pkg::div_status_type       status
);
   import plse_pkg::*;

   localparam int STEP_CYCLES = FRAC_BITS / DIV_STEPS;
   localparam int CNT_BITS    = $clog2(STEP_CYCLES);

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [WL_W-1:0]       rem_ff, rem_in;
   logic [WL_W-1:0]       half_ff, half_in;
   logic [WL_W-1:0]       den_ff, den_in;
   logic [FRAC_BITS:0]    quot_ff, quot_in;
   logic                  last_step;

   // remainder steps for this cycle
   always_comb begin
      logic [WL_W-1:0]      rem_v;
      logic [WL_W-1:0]      half_v;
      logic [DIV_STEPS-1:0] bits_v;
      logic [WL_W:0]        trial;
      logic [WL_W:0]        diff;
      rem_v  = rem_ff;
      half_v = half_ff;
      bits_v = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial  = {rem_v, half_v[WL_W-1]};
         half_v = {half_v[WL_W-2:0], 1'b0};
         diff   = trial - {1'b0, den_ff};
         if (trial >= {1'b0, den_ff}) begin
            rem_v  = diff[WL_W-1:0];
            bits_v = {bits_v[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_v  = trial[WL_W-1:0];
            bits_v = {bits_v[DIV_STEPS-2:0], 1'b0};
         end
      end

      last_step = busy_ff && (cnt_ff == CNT_BITS'(STEP_CYCLES - 1));
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      half_in   = half_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;

      if (start) begin
         // integer part: num == den gives exactly one, remainder zero
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         half_in = den >> 1;
         if (num >= den) begin
            rem_in  = '0;
            quot_in = FRAC_ONE;
         end else begin
            rem_in  = num;
            quot_in = '0;
         end
      end else if (busy_ff) begin
         rem_in  = rem_v;
         half_in = half_v;
         quot_in = {quot_ff[FRAC_BITS], quot_ff[FRAC_BITS-DIV_STEPS-1:0], bits_v};
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      half_ff <= half_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign quot        = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = last_step;

endmodule
